[rtl/sctbl_pkg.sv]
// Shared types and constants for the calibration table interpolator.
`default_nettype none

package sctbl_pkg;

    localparam int VOLT_W     = 12;
    localparam int VAL_W      = 14;
    localparam int ST_W       = 4;
    localparam int CNT_OUT_W  = 5;
    localparam int PROD_W     = VAL_W + VOLT_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;

    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LIMIT  = 1'b1;

    localparam logic [VAL_W-1:0]  VALUE_LIMIT_RST = 14'd10000;
    localparam logic [VOLT_W-1:0] VOLT_LIMIT_RST  = 12'd3300;
    localparam logic [VOLT_W-1:0] ENTRY1_VOLT_RST = 12'd3300;
    localparam logic [VAL_W-1:0]  ENTRY1_VAL_RST  = 14'd10000;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 4'd0,
        ST_UPDATED     = 4'd1,
        ST_VALUE_RANGE = 4'd2,
        ST_FULL        = 4'd3,
        ST_VOLT_RANGE  = 4'd4,
        ST_BELOW_FIRST = 4'd5,
        ST_VALUE_ORDER = 4'd6,
        ST_VOLT_ORDER  = 4'd7,
        ST_NO_SEGMENT  = 4'd8
    } status_t;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [VAL_W-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/sctbl_mem.sv]
// Calibration pair memory: one write port, one registered read port.
`default_nettype none

module sctbl_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire sctbl_pkg::entry_t        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output sctbl_pkg::entry_t             rdata
);

    localparam int AW = $clog2(DEPTH);

    sctbl_pkg::entry_t mem [DEPTH];
    sctbl_pkg::entry_t rd_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
            rd_addr_reg  <= raddr;
        end
    end

    // unwritten entries read as their reset contents
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rdata = rd_reg;
        end
        else if (rd_addr_reg == AW'(1))
        begin
            rdata.volt  = sctbl_pkg::ENTRY1_VOLT_RST;
            rdata.value = sctbl_pkg::ENTRY1_VAL_RST;
        end
        else
        begin
            rdata = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/sctbl_div.sv]
// Restoring divider, one quotient bit per cycle, for the interpolation step.
`default_nettype none

module sctbl_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [sctbl_pkg::ACC_W-1:0]    dividend,
    input  wire logic [sctbl_pkg::VOLT_W-1:0]   divisor,
    output sctbl_pkg::div_stat_t                stat,
    output logic [sctbl_pkg::VAL_W-1:0]         quotient
);

    localparam int QW   = sctbl_pkg::VAL_W;
    localparam int RW   = sctbl_pkg::VOLT_W;
    localparam int CW   = $clog2(QW + 1);

    logic [RW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [RW:0]   trial;
    logic          ge;

    // dividend is below divisor * 2^QW, so the top bits start below the divisor
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(QW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[RW+QW-1:QW];
            quo_reg <= dividend[QW-1:0];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign stat     = '{busy: (cnt_reg != '0), done: done_reg};
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/sorted_calibration_table_interpolator_unit.sv]
// Calibration table interpolator top level: sequencer, shared multiplier, ports.
`default_nettype none

// Piecewise-linear calibration table mapping millivolts to hundredths of
// concentration. Each input beat carries a command on s_tuser: add (0) puts a
// (voltage, concentration) pair into the voltage-sorted table, or replaces the
// voltage of the pair that already has that concentration; convert (1) returns
// the exact-match concentration or the rounded linear interpolation in the
// first segment that holds the voltage and gives a result within the value
// limit, else the previous result with a no-segment status. Every input beat
// yields exactly one output beat with the held result, a status code and the
// pair count. One item is in work at a time and s_tready is low until its
// result is handed to the output register. Timing is set by the table
// memory's single read port and the shared units. A convert scans the pairs
// and, for every segment tried, makes two passes through the shared
// multiplier, a divider start, 14 steps of the one-bit-per-cycle divider and
// its done flag, and re-reads the table after a segment is skipped. An add
// runs the match scan, where a below-first reject ends. An insert then
// moves up each pair that lies above the new voltage, settles the slot and
// writes the pair. The order check walks the pairs and stops at the first
// fault, then the result is handed off; range rejects go straight from the
// checks to the handoff. Table reset is held by per-entry valid bits, so
// there is no clearing pass. The limit registers are written through the
// cfg channel, which is always ready; the user must write them only while
// the block is idle, as the block itself does not enforce this.

module sorted_calibration_table_interpolator_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sctbl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sctbl_pkg::VAL_W-1:0]          cfg_data,
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [sctbl_pkg::IN_DATA_W-1:0]      s_tdata,   // voltage_mv[11:0], target_value[25:12]
    input  wire logic                                 s_tuser,   // cmd[0]
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [sctbl_pkg::OUT_DATA_W-1:0]          m_tdata    // value_out[13:0], status[17:14], pair_count[22:18]
);

    localparam int VOLT_W = sctbl_pkg::VOLT_W;
    localparam int VAL_W  = sctbl_pkg::VAL_W;
    localparam int ACC_W  = sctbl_pkg::ACC_W;
    localparam int PROD_W = sctbl_pkg::PROD_W;
    localparam int CNT_W  = sctbl_pkg::CNT_OUT_W;
    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] FULL_CNT = IW'(TABLE_DEPTH - 1);
    localparam logic [IW-1:0] RST_CNT  = IW'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CV_SCAN,
        S_CV_RD,
        S_MUL1,
        S_MUL2,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ADD_CHK,
        S_ADD_SCAN,
        S_SH_RD,
        S_SH_CMP,
        S_INS_WR,
        S_ORD_RD0,
        S_ORD_SCAN,
        S_RES
    } state_t;

    state_t                          state_reg;
    logic [VOLT_W-1:0]               volt_in_reg;
    logic [VAL_W-1:0]                val_in_reg;
    logic [IW-1:0]                   idx_reg;
    logic [IW-1:0]                   count_reg;
    logic [VAL_W-1:0]                last_reg;
    sctbl_pkg::status_t              status_reg;
    logic                            upd_reg;
    logic [VOLT_W-1:0]               first_volt_reg;
    sctbl_pkg::entry_t               prev_reg;
    logic [VAL_W-1:0]                lo_reg;
    logic [VAL_W-1:0]                hi_reg;
    logic [VOLT_W-1:0]               a_reg;
    logic [VOLT_W-1:0]               b_reg;
    logic [VOLT_W-1:0]               d_reg;
    logic [ACC_W-1:0]                acc_reg;
    logic [VAL_W-1:0]                tlim_reg;
    logic [VOLT_W-1:0]               vlim_reg;
    logic                            m_tvalid_reg;
    logic [sctbl_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // memory and shared unit hookup
    sctbl_pkg::entry_t               cur;
    sctbl_pkg::entry_t               wdata;
    logic                            we;
    logic [IW-1:0]                   waddr;
    logic [IW-1:0]                   rd_addr;
    logic                            div_start;
    sctbl_pkg::div_stat_t            div_stat;
    logic [VAL_W-1:0]                div_quot;
    logic [VAL_W-1:0]                mul_x;
    logic [VOLT_W-1:0]               mul_y;
    logic [PROD_W-1:0]               prod;

    // scan decisions on the entry arriving from memory
    logic [IW-1:0]                   idx_inc;
    logic                            last_idx;
    logic                            seg_fit;
    logic                            exact;
    logic                            match_val;
    logic                            below;
    logic                            shift_go;
    logic                            bad_val;
    logic                            bad_volt;
    logic                            q_ok;

    assign idx_inc   = idx_reg + 1'b1;
    assign last_idx  = idx_inc == count_reg;
    assign seg_fit   = (idx_reg != '0) && (volt_in_reg > prev_reg.volt)
                       && (volt_in_reg < cur.volt);
    assign exact     = volt_in_reg == cur.volt;
    assign match_val = cur.value == val_in_reg;
    assign below     = volt_in_reg < ((idx_reg == '0) ? cur.volt : first_volt_reg);
    assign shift_go  = volt_in_reg < cur.volt;
    assign bad_val   = cur.value < prev_reg.value;
    assign bad_volt  = cur.volt < prev_reg.volt;
    assign q_ok      = div_quot <= tlim_reg;

    sctbl_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (cur)
    );

    sctbl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (d_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // shared multiplier: lo*(vhi-v) first, then hi*(v-vlo)
    assign mul_x = (state_reg == S_MUL1) ? lo_reg : hi_reg;
    assign mul_y = (state_reg == S_MUL1) ? a_reg : b_reg;
    assign prod  = mul_x * mul_y;

    // memory address and write decode
    always_comb
    begin
        rd_addr     = '0;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata.volt  = volt_in_reg;
        wdata.value = val_in_reg;
        div_start   = 1'b0;
        case (state_reg)
            S_CV_SCAN:
            begin
                if (!seg_fit && !exact && !last_idx)
                begin
                    rd_addr = idx_inc;
                end
            end
            S_CV_RD:
            begin
                rd_addr = idx_reg;
            end
            S_DIV_GO:
            begin
                div_start = 1'b1;
            end
            S_ADD_SCAN:
            begin
                if (match_val)
                begin
                    we = 1'b1;
                end
                else if (!last_idx)
                begin
                    rd_addr = idx_inc;
                end
            end
            S_SH_RD:
            begin
                if (idx_reg != '0)
                begin
                    rd_addr = idx_reg - 1'b1;
                end
            end
            S_SH_CMP:
            begin
                if (shift_go)
                begin
                    we    = 1'b1;
                    wdata = cur;
                end
            end
            S_INS_WR:
            begin
                we = 1'b1;
            end
            S_ORD_SCAN:
            begin
                if (!last_idx && ((idx_reg == '0) || (!bad_val && !bad_volt)))
                begin
                    rd_addr = idx_inc;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlim_reg <= sctbl_pkg::VALUE_LIMIT_RST;
            vlim_reg <= sctbl_pkg::VOLT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sctbl_pkg::CFG_VALUE_LIMIT: tlim_reg <= cfg_data;
                sctbl_pkg::CFG_VOLT_LIMIT:  vlim_reg <= cfg_data[VOLT_W-1:0];
                default:                    tlim_reg <= tlim_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= RST_CNT;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // drop valid once the beat is taken, unless a new result replaces it
            if (m_tvalid_reg && m_tready && (state_reg != S_RES))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        volt_in_reg <= s_tdata[VOLT_W-1:0];
                        val_in_reg  <= s_tdata[VOLT_W+VAL_W-1:VOLT_W];
                        idx_reg     <= '0;
                        if (s_tuser == sctbl_pkg::CMD_CONVERT)
                        begin
                            if (count_reg == '0)
                            begin
                                status_reg <= sctbl_pkg::ST_NO_SEGMENT;
                                state_reg  <= S_RES;
                            end
                            else
                            begin
                                state_reg <= S_CV_SCAN;
                            end
                        end
                        else
                        begin
                            state_reg <= S_ADD_CHK;
                        end
                    end
                end
                S_CV_SCAN:
                begin
                    prev_reg <= cur;
                    if (seg_fit)
                    begin
                        lo_reg    <= prev_reg.value;
                        hi_reg    <= cur.value;
                        a_reg     <= cur.volt - volt_in_reg;
                        b_reg     <= volt_in_reg - prev_reg.volt;
                        d_reg     <= cur.volt - prev_reg.volt;
                        state_reg <= S_MUL1;
                    end
                    else if (exact)
                    begin
                        last_reg   <= cur.value;
                        status_reg <= sctbl_pkg::ST_OK;
                        state_reg  <= S_RES;
                    end
                    else if (last_idx)
                    begin
                        status_reg <= sctbl_pkg::ST_NO_SEGMENT;
                        state_reg  <= S_RES;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_CV_RD:
                begin
                    state_reg <= S_CV_SCAN;
                end
                S_MUL1:
                begin
                    acc_reg   <= ACC_W'(prod);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    // add half the divisor so halves round up
                    acc_reg   <= acc_reg + ACC_W'(prod) + ACC_W'(d_reg >> 1);
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        if (q_ok)
                        begin
                            last_reg   <= div_quot;
                            status_reg <= sctbl_pkg::ST_OK;
                            state_reg  <= S_RES;
                        end
                        else if (last_idx)
                        begin
                            status_reg <= sctbl_pkg::ST_NO_SEGMENT;
                            state_reg  <= S_RES;
                        end
                        else
                        begin
                            // skip the segment, re-read the next entry
                            idx_reg   <= idx_inc;
                            state_reg <= S_CV_RD;
                        end
                    end
                end
                S_ADD_CHK:
                begin
                    if (val_in_reg > tlim_reg)
                    begin
                        status_reg <= sctbl_pkg::ST_VALUE_RANGE;
                        state_reg  <= S_RES;
                    end
                    else if (count_reg >= FULL_CNT)
                    begin
                        status_reg <= sctbl_pkg::ST_FULL;
                        state_reg  <= S_RES;
                    end
                    else if (volt_in_reg > vlim_reg)
                    begin
                        status_reg <= sctbl_pkg::ST_VOLT_RANGE;
                        state_reg  <= S_RES;
                    end
                    else if (count_reg == '0)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_INS_WR;
                    end
                    else
                    begin
                        state_reg <= S_ADD_SCAN;
                    end
                end
                S_ADD_SCAN:
                begin
                    if (idx_reg == '0)
                    begin
                        first_volt_reg <= cur.volt;
                    end
                    if (match_val)
                    begin
                        upd_reg   <= 1'b1;
                        state_reg <= S_ORD_RD0;
                    end
                    else if (last_idx)
                    begin
                        if (below)
                        begin
                            status_reg <= sctbl_pkg::ST_BELOW_FIRST;
                            state_reg  <= S_RES;
                        end
                        else
                        begin
                            idx_reg   <= count_reg;
                            state_reg <= S_SH_RD;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_SH_RD:
                begin
                    state_reg <= (idx_reg == '0) ? S_INS_WR : S_SH_CMP;
                end
                S_SH_CMP:
                begin
                    if (shift_go)
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        state_reg <= S_INS_WR;
                    end
                end
                S_INS_WR:
                begin
                    count_reg <= count_reg + 1'b1;
                    upd_reg   <= 1'b0;
                    state_reg <= S_ORD_RD0;
                end
                S_ORD_RD0:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_ORD_SCAN;
                end
                S_ORD_SCAN:
                begin
                    prev_reg <= cur;
                    if ((idx_reg != '0) && bad_val)
                    begin
                        status_reg <= sctbl_pkg::ST_VALUE_ORDER;
                        state_reg  <= S_RES;
                    end
                    else if ((idx_reg != '0) && bad_volt)
                    begin
                        status_reg <= sctbl_pkg::ST_VOLT_ORDER;
                        state_reg  <= S_RES;
                    end
                    else if (last_idx)
                    begin
                        status_reg <= upd_reg ? sctbl_pkg::ST_UPDATED : sctbl_pkg::ST_OK;
                        state_reg  <= S_RES;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                S_RES:
                begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, CNT_W'(count_reg), status_reg, last_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == S_IDLE;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("pair count above table capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("pair count changed by other than one");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[17:14] <= sctbl_pkg::ST_NO_SEGMENT))
        else $error("status code out of range");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIV_WAIT))
        else $error("divider running outside the divide wait");
`endif

endmodule

`default_nettype wire
